// ===== hw/rtl/clns_pkg.sv =====
// Shared types, codes and the per-step nibble table of the character LCD nibble sequencer.
package clns_pkg;

    localparam int CHAR_W    = 8;
    localparam int ADDR_W    = 7;
    localparam int NIB_W     = 4;
    localparam int BEFORE_W  = 14;
    localparam int AFTER_W   = 13;
    localparam int MARGIN_W  = 8;
    localparam int STEP_W    = 4;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int TDATA_W   = 32;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BKSP  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd3;

    // Nibble sources.
    localparam logic [2:0] SRC_CONST   = 3'd0;
    localparam logic [2:0] SRC_ADDR_HI = 3'd1;
    localparam logic [2:0] SRC_ADDR_LO = 3'd2;
    localparam logic [2:0] SRC_CHAR_HI = 3'd3;
    localparam logic [2:0] SRC_CHAR_LO = 3'd4;

    // Margin selection for the wait after a nibble.
    localparam logic [1:0] MRG_NONE = 2'd0;
    localparam logic [1:0] MRG_RUN  = 2'd1;
    localparam logic [1:0] MRG_INIT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MARGIN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MARGIN = 1'd1;

    localparam logic [MARGIN_W-1:0] RUN_MARGIN_RESET  = 8'd20;
    localparam logic [MARGIN_W-1:0] INIT_MARGIN_RESET = 8'd100;

    localparam logic [CHAR_W-1:0] CHAR_CLEAR = 8'h7E;
    localparam logic [CHAR_W-1:0] CHAR_BKSP  = 8'h08;

    localparam logic [ADDR_W-1:0] ADDR_LINE1_END   = 7'h0F;
    localparam logic [ADDR_W-1:0] ADDR_LINE2_START = 7'h40;
    localparam logic [ADDR_W-1:0] ADDR_LINE2_END   = 7'h4F;

    localparam logic [BEFORE_W-1:0] POWERUP_WAIT_US = 14'd15000;

    typedef struct packed {
        logic                rs;
        logic [2:0]          src;
        logic [NIB_W-1:0]    nib;
        logic                first;
        logic [AFTER_W-1:0]  after_base;
        logic [1:0]          margin;
        logic                last;
    } nib_spec_t;

    typedef struct packed {
        logic              capture;
        logic              load;
        logic [STEP_W-1:0] step;
    } clns_cmd_t;

    typedef struct packed {
        logic out_free;
        logic skip;
        logic last;
    } clns_status_t;

    function automatic nib_spec_t mk(input logic rs, input logic [2:0] src,
                                     input logic [NIB_W-1:0] nib,
                                     input logic [AFTER_W-1:0] after_base,
                                     input logic [1:0] margin, input logic last);
        nib_spec_t s;
        s.rs         = rs;
        s.src        = src;
        s.nib        = nib;
        s.first      = 1'b0;
        s.after_base = after_base;
        s.margin     = margin;
        s.last       = last;
        return s;
    endfunction

    // One table row per nibble of each item kind.
    function automatic nib_spec_t nib_spec(input logic [KIND_W-1:0] kind,
                                           input logic [STEP_W-1:0] step);
        nib_spec_t s;
        s = mk(1'b0, SRC_CONST, 4'h0, 13'd0, MRG_NONE, 1'b1);
        case (kind)
            KIND_INIT: begin
                case (step)
                    4'd0: begin
                        s = mk(1'b0, SRC_CONST, 4'h3, 13'd4100, MRG_INIT, 1'b0);
                        s.first = 1'b1;
                    end
                    4'd1:  s = mk(1'b0, SRC_CONST, 4'h3, 13'd100,  MRG_INIT, 1'b0);
                    4'd2:  s = mk(1'b0, SRC_CONST, 4'h3, 13'd40,   MRG_INIT, 1'b0);
                    4'd3:  s = mk(1'b0, SRC_CONST, 4'h2, 13'd40,   MRG_INIT, 1'b0);
                    4'd4:  s = mk(1'b0, SRC_CONST, 4'h2, 13'd0,    MRG_NONE, 1'b0);
                    4'd5:  s = mk(1'b0, SRC_CONST, 4'h8, 13'd39,   MRG_INIT, 1'b0);
                    4'd6:  s = mk(1'b0, SRC_CONST, 4'h0, 13'd0,    MRG_NONE, 1'b0);
                    4'd7:  s = mk(1'b0, SRC_CONST, 4'h8, 13'd39,   MRG_INIT, 1'b0);
                    4'd8:  s = mk(1'b0, SRC_CONST, 4'h0, 13'd0,    MRG_NONE, 1'b0);
                    4'd9:  s = mk(1'b0, SRC_CONST, 4'h1, 13'd1530, MRG_INIT, 1'b0);
                    4'd10: s = mk(1'b0, SRC_CONST, 4'h0, 13'd0,    MRG_NONE, 1'b0);
                    4'd11: s = mk(1'b0, SRC_CONST, 4'h6, 13'd39,   MRG_INIT, 1'b0);
                    4'd12: s = mk(1'b0, SRC_CONST, 4'h0, 13'd0,    MRG_NONE, 1'b0);
                    default: s = mk(1'b0, SRC_CONST, 4'hF, 13'd39, MRG_RUN, 1'b1);
                endcase
            end
            KIND_CLEAR: begin
                case (step)
                    4'd0:    s = mk(1'b0, SRC_CONST, 4'h0, 13'd0,    MRG_NONE, 1'b0);
                    default: s = mk(1'b0, SRC_CONST, 4'h1, 13'd1530, MRG_RUN,  1'b1);
                endcase
            end
            KIND_BKSP: begin
                case (step)
                    4'd0: s = mk(1'b0, SRC_ADDR_HI, 4'h0, 13'd0,  MRG_NONE, 1'b0);
                    4'd1: s = mk(1'b0, SRC_ADDR_LO, 4'h0, 13'd39, MRG_RUN,  1'b0);
                    4'd2: s = mk(1'b1, SRC_CONST,   4'h2, 13'd0,  MRG_NONE, 1'b0);
                    4'd3: s = mk(1'b1, SRC_CONST,   4'h0, 13'd43, MRG_RUN,  1'b0);
                    4'd4: s = mk(1'b0, SRC_ADDR_HI, 4'h0, 13'd0,  MRG_NONE, 1'b0);
                    default: s = mk(1'b0, SRC_ADDR_LO, 4'h0, 13'd39, MRG_RUN, 1'b1);
                endcase
            end
            default: begin
                case (step)
                    4'd0: s = mk(1'b0, SRC_ADDR_HI, 4'h0, 13'd0,  MRG_NONE, 1'b0);
                    4'd1: s = mk(1'b0, SRC_ADDR_LO, 4'h0, 13'd39, MRG_RUN,  1'b0);
                    4'd2: s = mk(1'b1, SRC_CHAR_HI, 4'h0, 13'd0,  MRG_NONE, 1'b0);
                    default: s = mk(1'b1, SRC_CHAR_LO, 4'h0, 13'd43, MRG_RUN, 1'b1);
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/clns_datapath.sv =====
// Datapath: margins, cursor, captured item, nibble formation and the output register.
module clns_datapath import clns_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MARGIN_W-1:0]  cfg_data,
    input  logic                 in_mode,
    input  logic [CHAR_W-1:0]    in_char,
    input  clns_cmd_t            cmd,
    output clns_status_t         status,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic                 m_tlast,
    output logic                 m_reg_select,
    output logic [NIB_W-1:0]     m_nibble,
    output logic [BEFORE_W-1:0]  m_wait_before,
    output logic [AFTER_W-1:0]   m_wait_after
);

    logic [MARGIN_W-1:0] run_margin_reg;
    logic [MARGIN_W-1:0] init_margin_reg;
    logic [ADDR_W-1:0]   cursor_reg, cursor_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CHAR_W-1:0]   char_reg;
    logic [KIND_W-1:0]   kind_reg, in_kind;
    logic                valid_reg;
    logic                last_reg;
    logic                rs_reg;
    logic [NIB_W-1:0]    nib_reg, nib_next;
    logic [BEFORE_W-1:0] before_reg, before_next;
    logic [AFTER_W-1:0]  after_reg, after_next;
    logic [ADDR_W-1:0]   cursor_inc, cursor_dec;
    logic [MARGIN_W-1:0] margin;
    logic [CHAR_W-1:0]   addr_byte;
    nib_spec_t           spec;

    always_comb begin
        if (in_mode) begin
            in_kind = KIND_INIT;
        end else if (in_char == CHAR_CLEAR) begin
            in_kind = KIND_CLEAR;
        end else if (in_char == CHAR_BKSP) begin
            in_kind = KIND_BKSP;
        end else begin
            in_kind = KIND_CHAR;
        end
    end

    assign cursor_inc = cursor_reg + 7'd1;
    assign cursor_dec = (cursor_reg == ADDR_LINE2_START) ? ADDR_LINE1_END : cursor_reg - 7'd1;

    // The backspace steps the cursor before its address is sent; a character uses
    // the current address and moves the cursor afterward, wrapping between lines.
    always_comb begin
        cursor_next = cursor_reg;
        addr_next   = addr_reg;
        case (in_kind)
            KIND_CLEAR: cursor_next = '0;
            KIND_BKSP: begin
                if (cursor_reg != '0) begin
                    cursor_next = cursor_dec;
                    addr_next   = cursor_dec;
                end
            end
            KIND_CHAR: begin
                addr_next = cursor_reg;
                if (cursor_inc > ADDR_LINE1_END && cursor_inc < ADDR_LINE2_START) begin
                    cursor_next = ADDR_LINE2_START;
                end else if (cursor_inc > ADDR_LINE2_END) begin
                    cursor_next = '0;
                end else begin
                    cursor_next = cursor_inc;
                end
            end
            default: cursor_next = cursor_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_margin_reg  <= RUN_MARGIN_RESET;
            init_margin_reg <= INIT_MARGIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RUN_MARGIN:  run_margin_reg  <= cfg_data;
                CFG_INIT_MARGIN: init_margin_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else if (cmd.capture) begin
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            addr_reg <= addr_next;
            char_reg <= in_char;
            kind_reg <= in_kind;
        end
    end

    assign spec      = nib_spec(kind_reg, cmd.step);
    assign addr_byte = {1'b1, addr_reg};

    always_comb begin
        case (spec.margin)
            MRG_RUN:  margin = run_margin_reg;
            MRG_INIT: margin = init_margin_reg;
            default:  margin = '0;
        endcase
    end

    always_comb begin
        case (spec.src)
            SRC_ADDR_HI: nib_next = addr_byte[7:4];
            SRC_ADDR_LO: nib_next = addr_byte[3:0];
            SRC_CHAR_HI: nib_next = char_reg[7:4];
            SRC_CHAR_LO: nib_next = char_reg[3:0];
            default:     nib_next = spec.nib;
        endcase
    end

    assign after_next  = spec.after_base + {{(AFTER_W-MARGIN_W){1'b0}}, margin};
    assign before_next = spec.first
                       ? POWERUP_WAIT_US + {{(BEFORE_W-MARGIN_W){1'b0}}, init_margin_reg}
                       : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rs_reg     <= spec.rs;
            nib_reg    <= nib_next;
            before_reg <= before_next;
            after_reg  <= after_next;
            last_reg   <= spec.last;
        end
    end

    assign status.out_free = !valid_reg || m_tready;
    assign status.skip     = (in_kind == KIND_BKSP) && (cursor_reg == '0);
    assign status.last     = spec.last;

    assign m_tvalid      = valid_reg;
    assign m_tlast       = last_reg;
    assign m_reg_select  = rs_reg;
    assign m_nibble      = nib_reg;
    assign m_wait_before = before_reg;
    assign m_wait_after  = after_reg;

endmodule

// ===== hw/rtl/clns_controller.sv =====
// Controller: takes one item at a time and walks its nibble steps into the output register.
module clns_controller import clns_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  clns_status_t status,
    output clns_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic              state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd.capture = accept;
        cmd.load    = 1'b0;
        cmd.step    = step_reg;
        case (state_reg)
            ST_IDLE: begin
                // A backspace at the home position sends nothing.
                if (accept && !status.skip) begin
                    state_next = ST_BUSY;
                    step_next  = '0;
                end
            end
            ST_BUSY: begin
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== hw/rtl/char_lcd_nibble_sequencer_unit.sv =====
// Top level of the character LCD nibble sequencer.
// Each accepted beat becomes a run of 4-bit LCD transfers, one result beat per nibble,
// with m_tlast on the final nibble of the run. Power-up init yields fourteen beats, a
// clear two, a backspace six (none at the home position) and any other character four.
// The controller loads one nibble a cycle into the output register while it is free, and
// takes no new input beat until it has loaded the last nibble of the item; the next input
// beat is taken while the last nibble still waits on m_tready.
// Configuration writes are taken in any cycle and should be made while the block is idle.
module char_lcd_nibble_sequencer_unit import clns_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MARGIN_W-1:0]  cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CHAR_W-1:0]    s_tdata,   // [7:0] char_code
    input  logic [0:0]           s_tuser,   // [0] mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [3:0] nibble, [17:4] wait_before_us,
                                            // [30:18] wait_after_us, [31] zero
    output logic [0:0]           m_tuser,   // [0] reg_select
    output logic                 m_tlast
);

    clns_cmd_t           cmd;
    clns_status_t        status;
    logic                reg_select;
    logic [NIB_W-1:0]    nibble;
    logic [BEFORE_W-1:0] wait_before;
    logic [AFTER_W-1:0]  wait_after;

    assign cfg_ready = 1'b1;

    clns_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    clns_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_mode       (s_tuser[0]),
        .in_char       (s_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tlast       (m_tlast),
        .m_reg_select  (reg_select),
        .m_nibble      (nibble),
        .m_wait_before (wait_before),
        .m_wait_after  (wait_after)
    );

    assign m_tdata = {1'b0, wait_after, wait_before, nibble};
    assign m_tuser = reg_select;

endmodule
